>>> design/infix_to_postfix_converter_top_macros.svh
// assertion macros shared by the checker
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define IPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipc assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define IPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipc assertion failed");

`endif

>>> design/ipc_pkg.sv
package ipc_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ErrW  = 2;

  // error flag bit positions
  localparam int unsigned ERR_FULL      = 0;
  localparam int unsigned ERR_UNMATCHED = 1;

  // characters with a role of their own
  localparam logic [CharW-1:0] CH_MUL    = 8'h2A;
  localparam logic [CharW-1:0] CH_DIV    = 8'h2F;
  localparam logic [CharW-1:0] CH_ADD    = 8'h2B;
  localparam logic [CharW-1:0] CH_SUB    = 8'h2D;
  localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
  localparam logic [CharW-1:0] CH_RPAREN = 8'h29;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             finish;
  } ipc_in_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             expr_done;
    logic [ErrW-1:0]  errors;
    logic             last;
  } ipc_out_t;

  // shift controls shared by every cell in the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_e;

  function automatic logic is_alnum(logic [CharW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [1:0] prec_of(logic [CharW-1:0] c);
    logic [1:0] p;
    if ((c == CH_MUL) || (c == CH_DIV)) begin
      p = 2'd2;
    end else if ((c == CH_ADD) || (c == CH_SUB)) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

endpackage

>>> design/infix_to_postfix_converter_top.sv
// An item is taken into the item register while idle and handled in the processing
// state; a letter or digit goes on from there to the output register when it is free.
// No new item is taken until the last is handled; pops from the operator stack (a row
// of shift cells, one pop per cycle while the output does not stall) hold the input.
// Reset clears the control, the entry count and the error flags; stack cells hold
// no reset value and are only read below the entry count.
module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ipc_pkg::ipc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ipc_pkg::ipc_out_t out_data_o
);
  import ipc_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  state_e           state_d, state_q;
  logic [CntW-1:0]  count_d, count_q;
  logic [ErrW-1:0]  err_d, err_q;
  ipc_in_t          item_q;
  ipc_out_t         out_d, out_q;
  logic             out_valid_d, out_valid_q;
  logic             out_free;
  logic             emit;
  ipc_out_t         emit_data;
  cell_ctl_t        ctl;
  logic [CharW-1:0] cell_data [STACK_DEPTH];
  logic [CharW-1:0] top_ch, nxt_ch, cur_ch;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign top_ch     = cell_data[0];
  assign nxt_ch     = cell_data[1];
  assign cur_ch     = item_q.char_in;

  // operator stack: row of cells, top entry in cell 0
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [CharW-1:0] up, dn;
    if (g == 0) begin : g_first
      assign up = cur_ch;
    end else begin : g_mid
      assign up = cell_data[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_lastc
      assign dn = '0;
    end else begin : g_below
      assign dn = cell_data[g+1];
    end
    ipc_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .up_i   (up),
      .dn_i   (dn),
      .data_o (cell_data[g])
    );
  end

  // next state, stack control and result selection
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    err_d     = err_q;
    ctl       = '0;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        priority if (item_q.finish) begin
          // flush, then terminator with the sticky flags
          if (count_q != '0) begin
            if (out_free) begin
              emit               = 1'b1;
              emit_data.char_out = top_ch;
              ctl.pop            = 1'b1;
              count_d            = count_q - CntW'(1);
            end
          end else if (out_free) begin
            emit                = 1'b1;
            emit_data.expr_done = 1'b1;
            emit_data.errors    = err_q;
            emit_data.last      = 1'b1;
            err_d               = '0;
            state_d             = ST_IDLE;
          end
        end else if (is_alnum(cur_ch)) begin
          if (out_free) begin
            emit               = 1'b1;
            emit_data.char_out = cur_ch;
            emit_data.last     = 1'b1;
            state_d            = ST_IDLE;
          end
        end else if (cur_ch == CH_RPAREN) begin
          // pop down to the matching open parenthesis
          if ((count_q != '0) && (top_ch != CH_LPAREN)) begin
            if (out_free) begin
              emit               = 1'b1;
              emit_data.char_out = top_ch;
              emit_data.last     = (count_q == CntW'(1)) || (nxt_ch == CH_LPAREN);
              ctl.pop            = 1'b1;
              count_d            = count_q - CntW'(1);
            end
          end else begin
            if (count_q != '0) begin
              ctl.pop = 1'b1;
              count_d = count_q - CntW'(1);
            end else begin
              err_d[ERR_UNMATCHED] = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end else if ((cur_ch != CH_LPAREN) && (count_q != '0) &&
                     (prec_of(cur_ch) <= prec_of(top_ch))) begin
          // operator pops entries of no lower precedence
          if (out_free) begin
            emit               = 1'b1;
            emit_data.char_out = top_ch;
            emit_data.last     = (count_q == CntW'(1)) ||
                                 (prec_of(cur_ch) > prec_of(nxt_ch));
            ctl.pop            = 1'b1;
            count_d            = count_q - CntW'(1);
          end
        end else begin
          // push, dropped when full
          if (count_q == CntW'(STACK_DEPTH)) begin
            err_d[ERR_FULL] = 1'b1;
          end else begin
            ctl.push = 1'b1;
            count_d  = count_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/ipc_cell.sv
module ipc_cell (
  input  logic                       clk_i,
  input  ipc_pkg::cell_ctl_t         ctl_i,
  input  logic [ipc_pkg::CharW-1:0]  up_i,
  input  logic [ipc_pkg::CharW-1:0]  dn_i,
  output logic [ipc_pkg::CharW-1:0]  data_o
);
  import ipc_pkg::*;

  logic [CharW-1:0] data_d, data_q;

  // push takes the entry above, pop takes the entry below
  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = up_i;
    end else if (ctl_i.pop) begin
      data_d = dn_i;
    end
  end

  // stack entry, undefined until pushed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> design/ipc_checker.sv
`include "infix_to_postfix_converter_top_macros.svh"

module ipc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ipc_pkg::ipc_out_t out_data_o
);
  import ipc_pkg::*;

  // an accepted item keeps the input stalled while it is handled
  `IPC_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result stays offered
  `IPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // the terminator always closes the item's results
  `IPC_ASSERT_IMPL(a_done_last, out_valid_o && out_data_o.expr_done, out_data_o.last)

  // terminator carries no character
  `IPC_ASSERT_IMPL(a_done_char, out_valid_o && out_data_o.expr_done, out_data_o.char_out == '0)

  // error flags only travel on the terminator
  `IPC_ASSERT_IMPL(a_err_term, out_valid_o && !out_data_o.expr_done, out_data_o.errors == '0)

endmodule

bind infix_to_postfix_converter_top ipc_checker u_ipc_checker (.*);
